/* hw/rtl/tcce_pkg.sv */
package tcce_pkg;

  // Default screen geometry and tab width.
  localparam int COLUMNS_DEF    = 80;
  localparam int ROWS_DEF       = 25;
  localparam int TAB_SPACES_DEF = 8;

  // Field widths of the request and result items.
  localparam int CMD_W     = 2;
  localparam int CHR_W     = 8;
  localparam int ATTR_W    = 4;
  localparam int IDX_W     = 11;
  localparam int CURSOR_W  = 11;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Character codes that are obeyed rather than printed, and the space code.
  localparam logic [CHR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] CLEAR_ATTR = 4'h7;

  // One screen cell.
  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHR_W-1:0]  chr;
  } cell_t;

  // Port strobes from the sequencer to the cell store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctrl_t;

endpackage

/* hw/rtl/tcce_cell_store.sv */
module tcce_cell_store #(
  parameter int DEPTH = tcce_pkg::COLUMNS_DEF * tcce_pkg::ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  tcce_pkg::store_ctrl_t ctrl_i,
  input  logic [AW-1:0]        waddr_i,
  input  tcce_pkg::cell_t      wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output tcce_pkg::cell_t      rdata_o
);
  import tcce_pkg::*;

  cell_t mem_q [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tcce_seq.sv */
module tcce_seq #(
  parameter int COLUMNS    = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS       = tcce_pkg::ROWS_DEF,
  parameter int TAB_SPACES = tcce_pkg::TAB_SPACES_DEF,
  localparam int CELLS = COLUMNS * ROWS,
  localparam int AW    = $clog2(CELLS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tcce_pkg::CMD_W-1:0]     cmd_i,
  input  logic [tcce_pkg::CHR_W-1:0]     chr_i,
  input  logic [tcce_pkg::ATTR_W-1:0]    attr_i,
  input  logic [tcce_pkg::IDX_W-1:0]     idx_i,
  input  logic                           out_free_i,
  output logic                           ready_o,
  output logic                           done_o,
  output logic [tcce_pkg::CURSOR_W-1:0]  res_cursor_o,
  output logic [tcce_pkg::CHR_W-1:0]     res_chr_o,
  output logic [tcce_pkg::ATTR_W-1:0]    res_attr_o,
  output logic                           res_scrolled_o,
  output tcce_pkg::store_ctrl_t          ctrl_o,
  output logic [AW-1:0]                  waddr_o,
  output tcce_pkg::cell_t                wdata_o,
  output logic [AW-1:0]                  raddr_o,
  input  tcce_pkg::cell_t                rdata_i
);
  import tcce_pkg::*;

  localparam int POS_W = $clog2(2 * CELLS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int TAB_W = $clog2(TAB_SPACES + 1);
  localparam logic [POS_W-1:0] CELLS_P   = POS_W'(CELLS);
  localparam logic [POS_W-1:0] LAST_ROW  = POS_W'(CELLS - COLUMNS);
  localparam logic [POS_W-1:0] COLUMNS_P = POS_W'(COLUMNS);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);

  typedef enum logic [9:0] {
    ST_INIT    = 10'b00_0000_0001,
    ST_IDLE    = 10'b00_0000_0010,
    ST_CLEAR   = 10'b00_0000_0100,
    ST_PLAIN   = 10'b00_0000_1000,
    ST_CHECK   = 10'b00_0001_0000,
    ST_SCROLL  = 10'b00_0010_0000,
    ST_BS_RD   = 10'b00_0100_0000,
    ST_BS_WR   = 10'b00_1000_0000,
    ST_RD_WAIT = 10'b01_0000_0000,
    ST_FINISH  = 10'b10_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [POS_W-1:0]  cur_q, cur_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [POS_W-1:0]  cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic [TAB_W-1:0]  tab_q, tab_d;
  logic [CHR_W-1:0]  chr_q, chr_d;
  logic [ATTR_W-1:0] attr_q, attr_d;
  logic [CHR_W-1:0]  rc_q, rc_d;
  logic [ATTR_W-1:0] ra_q, ra_d;
  logic              sc_q, sc_d;

  // Shared cursor adder: every cursor move but a clear is cur_q plus a two's complement step.
  logic [POS_W-1:0]  addend;
  logic [POS_W-1:0]  cur_sum;

  always_comb begin
    addend = '0;
    case (state_q)
      ST_IDLE: begin
        if (chr_i == CH_NEWLINE) begin
          addend = COLUMNS_P - POS_W'(col_q);
        end else if (chr_i == CH_RETURN) begin
          addend = -POS_W'(col_q);
        end else if (cur_q <= POS_W'(1)) begin
          addend = -cur_q;
        end else begin
          addend = '1;
        end
      end
      ST_PLAIN:  addend = POS_W'(1);
      ST_SCROLL: addend = -COLUMNS_P;
      default:   addend = '0;
    endcase
  end

  assign cur_sum = cur_q + addend;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    col_d   = col_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    wa_d    = wa_q;
    tab_d   = tab_q;
    chr_d   = chr_q;
    attr_d  = attr_q;
    rc_d    = rc_q;
    ra_d    = ra_q;
    sc_d    = sc_q;
    ctrl_o  = '0;
    waddr_o = cur_q[AW-1:0];
    wdata_o = '{attr: attr_q, chr: chr_q};
    raddr_o = AW'(idx_i);
    done_o  = 1'b0;

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ctrl_o.wr_en = 1'b1;
        waddr_o      = cnt_q[AW-1:0];
        wdata_o      = '{attr: CLEAR_ATTR, chr: CH_SPACE};
        cnt_d        = cnt_q + POS_W'(1);
        if (cnt_q == CELLS_P - POS_W'(1)) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_FINISH;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          attr_d = attr_i;
          chr_d  = chr_i;
          tab_d  = '0;
          rc_d   = '0;
          ra_d   = '0;
          sc_d   = 1'b0;
          case (cmd_e'(cmd_i))
            CMD_PUT: begin
              case (chr_i)
                CH_NEWLINE, CH_RETURN: begin
                  cur_d   = cur_sum;
                  col_d   = '0;
                  state_d = ST_CHECK;
                end
                CH_TAB: begin
                  chr_d   = CH_SPACE;
                  tab_d   = TAB_W'(TAB_SPACES - 1);
                  state_d = ST_PLAIN;
                end
                CH_BACKSPACE: begin
                  cur_d = cur_sum;
                  if (cur_q <= POS_W'(1)) begin
                    col_d = '0;
                  end else if (col_q == '0) begin
                    col_d = LAST_COL;
                  end else begin
                    col_d = col_q - COL_W'(1);
                  end
                  state_d = ST_BS_RD;
                end
                default: state_d = ST_PLAIN;
              endcase
            end
            CMD_READ: begin
              if (32'(idx_i) < CELLS) begin
                ctrl_o.rd_en = 1'b1;
                state_d      = ST_RD_WAIT;
              end else begin
                state_d = ST_FINISH;
              end
            end
            CMD_CLEAR: begin
              cnt_d   = '0;
              cur_d   = '0;
              col_d   = '0;
              state_d = ST_CLEAR;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end

      ST_PLAIN: begin
        ctrl_o.wr_en = 1'b1;
        cur_d        = cur_sum;
        col_d        = (col_q == LAST_COL) ? '0 : col_q + COL_W'(1);
        state_d      = ST_CHECK;
      end

      ST_CHECK: begin
        if (cur_q >= CELLS_P) begin
          cnt_d   = '0;
          pend_d  = 1'b0;
          state_d = ST_SCROLL;
        end else if (tab_q != '0) begin
          tab_d   = tab_q - TAB_W'(1);
          state_d = ST_PLAIN;
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_SCROLL: begin
        // Reads run one cell ahead of the writes that use their data.
        if (cnt_q < CELLS_P) begin
          ctrl_o.rd_en = 1'b1;
          raddr_o = (cnt_q < LAST_ROW) ? AW'(cnt_q + COLUMNS_P) : cnt_q[AW-1:0];
          pend_d  = 1'b1;
          wa_d    = cnt_q[AW-1:0];
          cnt_d   = cnt_q + POS_W'(1);
        end else begin
          pend_d  = 1'b0;
          cur_d   = cur_sum;
          sc_d    = 1'b1;
          state_d = ST_CHECK;
        end
        if (pend_q) begin
          ctrl_o.wr_en = 1'b1;
          waddr_o      = wa_q;
          wdata_o      = rdata_i;
          if (POS_W'(wa_q) >= LAST_ROW) begin
            wdata_o.chr = CH_SPACE;
          end
        end
      end

      ST_BS_RD: begin
        ctrl_o.rd_en = 1'b1;
        raddr_o      = cur_q[AW-1:0];
        state_d      = ST_BS_WR;
      end

      ST_BS_WR: begin
        ctrl_o.wr_en = 1'b1;
        wdata_o      = '{attr: rdata_i.attr, chr: CH_SPACE};
        state_d      = ST_CHECK;
      end

      ST_RD_WAIT: begin
        rc_d    = rdata_i.chr;
        ra_d    = rdata_i.attr;
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cur_q   <= '0;
      col_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      tab_q   <= '0;
      sc_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      col_q   <= col_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      tab_q   <= tab_d;
      sc_q    <= sc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q   <= wa_d;
    chr_q  <= chr_d;
    attr_q <= attr_d;
    rc_q   <= rc_d;
    ra_q   <= ra_d;
  end

  assign ready_o        = (state_q == ST_IDLE);
  assign res_cursor_o   = CURSOR_W'(cur_q);
  assign res_chr_o      = rc_q;
  assign res_attr_o     = ra_q;
  assign res_scrolled_o = sc_q;

endmodule

/* hw/rtl/text_console_character_engine_core.sv */
// Text-mode console engine: a COLUMNS x ROWS store of cells (8-bit character,
// 4-bit attribute) and a cursor, driven by put character, read cell and clear
// requests, with one result per request. Requests are handled one at a time by
// a small sequencer that moves the cursor through a single shared adder and
// walks the cell memory, which has one write port and one registered read
// port. A tab is printed as TAB_SPACES spaces. A scroll rewrites every cell once
// from the row below, the last row with space characters; a clear rewrites every cell. After reset
// the engine fills the store with spaces of attribute 7 and holds s_axis_tready
// low meanwhile. The result waits in an output register, so the next request
// can be taken while the previous result is still pending on the master side.
module text_console_character_engine_core #(
  parameter int COLUMNS    = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS       = tcce_pkg::ROWS_DEF,
  parameter int TAB_SPACES = tcce_pkg::TAB_SPACES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: command[1:0], char_code[9:2], attribute[13:10],
  // cell_index[24:14], zero fill[31:25].
  input  logic [tcce_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: cursor_pos[10:0], read_char[18:11], read_attr[22:19],
  // scrolled[23].
  output logic [tcce_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  // Request fields, unpacked from the slave-side data word.
  logic [CMD_W-1:0]  in_cmd;
  logic [CHR_W-1:0]  in_chr;
  logic [ATTR_W-1:0] in_attr;
  logic [IDX_W-1:0]  in_idx;

  assign in_cmd  = s_axis_tdata[CMD_W-1:0];
  assign in_chr  = s_axis_tdata[CMD_W+CHR_W-1:CMD_W];
  assign in_attr = s_axis_tdata[CMD_W+CHR_W+ATTR_W-1:CMD_W+CHR_W];
  assign in_idx  = s_axis_tdata[CMD_W+CHR_W+ATTR_W+IDX_W-1:CMD_W+CHR_W+ATTR_W];

  logic              seq_ready;
  logic              seq_done;
  logic              out_free;
  logic [CURSOR_W-1:0] res_cursor;
  logic [CHR_W-1:0]  res_chr;
  logic [ATTR_W-1:0] res_attr;
  logic              res_scrolled;
  store_ctrl_t       store_ctrl;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  cell_t             wdata;
  cell_t             rdata;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // A request is accepted whenever the sequencer is idle; it does not wait for
  // the output register to drain, only a finished result does.
  assign s_axis_tready = seq_ready;
  assign out_free      = !out_valid_q || m_axis_tready;

  tcce_seq #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_SPACES(TAB_SPACES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (s_axis_tvalid && s_axis_tready),
    .cmd_i         (in_cmd),
    .chr_i         (in_chr),
    .attr_i        (in_attr),
    .idx_i         (in_idx),
    .out_free_i    (out_free),
    .ready_o       (seq_ready),
    .done_o        (seq_done),
    .res_cursor_o  (res_cursor),
    .res_chr_o     (res_chr),
    .res_attr_o    (res_attr),
    .res_scrolled_o(res_scrolled),
    .ctrl_o        (store_ctrl),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_o       (raddr),
    .rdata_i       (rdata)
  );

  tcce_cell_store #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .ctrl_i (store_ctrl),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Output register: loaded when the sequencer finishes, which it only does
  // once the previous result has been taken or is being taken this cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (seq_done) begin
      out_valid_d = 1'b1;
      out_data_d  = {res_scrolled, res_attr, res_chr, res_cursor};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* hw/rtl/tcce_checker.sv */
module tcce_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tcce_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tcce_pkg::*;

  logic in_acc;
  logic out_acc;
  logic [1:0] open_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Requests accepted whose results have not been taken yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !out_acc) begin
      open_q <= open_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      open_q <= open_q - 2'd1;
    end
  end

  // A stalled result holds its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Taking a request always leaves the engine busy, with s_axis_tready low, before it can take another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("engine ready right after taking a request");

  // A result is shown only for a request that was taken, and at most one
  // request waits behind a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || open_q != 2'd0) && (open_q != 2'd3) &&
    (!in_acc || open_q != 2'd2))
    else $error("result without request or too many requests open");

  // A scroll comes from a put, so its read fields are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[22:11] == 12'd0)
    else $error("scrolling result carries read data");

  // A result only goes away after it has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result withdrawn without being taken");

endmodule

bind text_console_character_engine_core tcce_checker u_tcce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
